/* design/tcce_pkg.sv */
`default_nettype none

package tcce_pkg;

	// default geometry
	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 8;

	// field widths of the item channels
	localparam int CMD_W   = 2;
	localparam int CODE_W  = 8;
	localparam int DIR_W   = 2;
	localparam int CADDR_W = 11;
	localparam int CIDX_W  = 11;
	localparam int CCOL_W  = 7;
	localparam int CROW_W  = 5;
	localparam int CELL_W  = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ARROW = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// arrow directions
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

	// character codes
	localparam logic [CODE_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CODE_W-1:0] CODE_TAB   = 8'h09;
	localparam logic [CODE_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CODE_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CODE_W-1:0] BLANK_CHAR = 8'h20;

	// configuration register
	localparam logic [7:0] ATTR_RESET = 8'h0F;
	localparam logic       REG_ATTR   = 1'b0;
	localparam int         PADDR_W    = 3;

	// prompt written after a line feed
	localparam int PROMPT_LEN   = 6;
	localparam int PROMPT_IDX_W = 3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [CODE_W-1:0]  char_code;
		logic [DIR_W-1:0]   direction;
		logic [CADDR_W-1:0] cell_address;
	} in_item_t;

	typedef struct packed {
		logic [CIDX_W-1:0] cursor_index;
		logic [CCOL_W-1:0] cursor_col;
		logic [CROW_W-1:0] cursor_row;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PROMPT,
		ST_SCROLL,
		ST_CLEAR,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_EXEC,
		OP_PROMPT,
		OP_SWEEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sweep_copy;
		logic   sweep_reset_blank;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_scroll;
		logic start_prompt;
		logic start_clear;
		logic prompt_last;
		logic sweep_done;
	} dp_status_t;

	function automatic logic [CODE_W-1:0] prompt_char(input logic [PROMPT_IDX_W-1:0] idx);
		logic [CODE_W-1:0] c;
		case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h65;
			3'd3: c = 8'h72;
			3'd4: c = 8'h3A;
			default: c = BLANK_CHAR;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* design/tcce_ram.sv */
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/tcce_dp.sv */
`default_nettype none

module tcce_dp #(
	parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           attr,
	input  wire tcce_pkg::in_item_t   req,
	input  wire tcce_pkg::dp_cmd_t    cmd,
	output tcce_pkg::dp_status_t      status,
	output tcce_pkg::out_item_t       rsp
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int CNT_W    = $clog2(CELLS + 1);
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int TAB_N    = 2 ** COL_W;
	localparam int PW       = tcce_pkg::PROMPT_IDX_W;
	localparam int CW       = tcce_pkg::CELL_W;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CELLS);
	localparam logic [CNT_W-1:0] COPY_END = CNT_W'(CELLS - COLUMNS);

	// cursor and per-item registers
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [PW-1:0]    prompt_q;
	logic             scroll_q;
	logic             read_hit_q, read_hit_d;

	// sweep counter and delayed write stage
	logic [CNT_W-1:0] sweep_q;
	logic             wr_v_s1;
	logic [AW-1:0]    wr_addr_s1;
	logic             copy_s1;

	// ram ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0]      cur_idx;
	logic [CW-1:0]      blank_cell;
	logic               last_row, wrap_col;
	logic [COL_W-1:0]   adv_col;
	logic [ROW_W-1:0]   nl_row, adv_row;
	logic               adv_scroll;
	logic               printable;
	logic               need_scroll, start_prompt, start_clear;

	// next tab stop per column, worked out at elaboration
	logic [COL_W-1:0] tab_col [TAB_N];
	logic             tab_wrap [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam int NEXT = (g / TAB_WIDTH + 1) * TAB_WIDTH;
		assign tab_col[g]  = COL_W'(NEXT);
		assign tab_wrap[g] = (NEXT >= COLUMNS) ? 1'b1 : 1'b0;
	end

	// cursor position as a linear cell index
	assign cur_idx = AW'(32'(row_q) * COLUMNS + 32'(col_q));

	// shared cursor advance for printable and prompt characters
	assign last_row   = (row_q == LAST_ROW);
	assign wrap_col   = (col_q == LAST_COL);
	assign nl_row     = last_row ? row_q : row_q + ROW_W'(1);
	assign adv_col    = wrap_col ? '0 : col_q + COL_W'(1);
	assign adv_row    = wrap_col ? nl_row : row_q;
	assign adv_scroll = wrap_col && last_row;
	assign printable  = (req.char_code[7:5] != 3'b000) && !req.char_code[7];

	assign blank_cell = cmd.sweep_reset_blank ? {tcce_pkg::ATTR_RESET, tcce_pkg::BLANK_CHAR}
	                                          : {attr, tcce_pkg::BLANK_CHAR};

	// step logic for the accepted item, prompt characters and sweeps
	always_comb begin
		col_d        = col_q;
		row_d        = row_q;
		read_hit_d   = read_hit_q;
		need_scroll  = 1'b0;
		start_prompt = 1'b0;
		start_clear  = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = cur_idx;
		ram_wdata    = {attr, tcce_pkg::BLANK_CHAR};
		ram_re       = 1'b0;
		ram_raddr    = AW'(req.cell_address);
		case (cmd.op)
			tcce_pkg::OP_EXEC: begin
				read_hit_d = 1'b0;
				case (req.cmd)
					tcce_pkg::CMD_PUT: begin
						case (req.char_code)
							tcce_pkg::CODE_BS: begin
								if (cur_idx != '0) begin
									ram_we    = 1'b1;
									ram_waddr = cur_idx - AW'(1);
									if (col_q == '0) begin
										col_d = LAST_COL;
										row_d = row_q - ROW_W'(1);
									end else begin
										col_d = col_q - COL_W'(1);
									end
								end
							end
							tcce_pkg::CODE_TAB: begin
								if (tab_wrap[col_q]) begin
									col_d       = '0;
									row_d       = nl_row;
									need_scroll = last_row;
								end else begin
									col_d = tab_col[col_q];
								end
							end
							tcce_pkg::CODE_CR: begin
								col_d = '0;
							end
							tcce_pkg::CODE_LF: begin
								col_d        = '0;
								row_d        = nl_row;
								need_scroll  = last_row;
								start_prompt = 1'b1;
							end
							default: begin
								if (printable) begin
									ram_we      = 1'b1;
									ram_wdata   = {attr, req.char_code};
									col_d       = adv_col;
									row_d       = adv_row;
									need_scroll = adv_scroll;
								end
							end
						endcase
					end
					tcce_pkg::CMD_ARROW: begin
						case (req.direction)
							tcce_pkg::DIR_LEFT: begin
								if (col_q != '0) begin
									col_d = col_q - COL_W'(1);
								end else if (row_q != '0) begin
									col_d = LAST_COL;
									row_d = row_q - ROW_W'(1);
								end
							end
							tcce_pkg::DIR_RIGHT: begin
								if (!wrap_col) begin
									col_d = col_q + COL_W'(1);
								end else if (!last_row) begin
									col_d = '0;
									row_d = row_q + ROW_W'(1);
								end
							end
							tcce_pkg::DIR_UP: begin
								if (row_q != '0) begin
									row_d = row_q - ROW_W'(1);
								end
							end
							default: begin
								if (!last_row) begin
									row_d = row_q + ROW_W'(1);
								end
							end
						endcase
					end
					tcce_pkg::CMD_CLEAR: begin
						col_d       = '0;
						row_d       = '0;
						start_clear = 1'b1;
					end
					default: begin
						if (32'(req.cell_address) < CELLS) begin
							ram_re     = 1'b1;
							read_hit_d = 1'b1;
						end
					end
				endcase
			end
			tcce_pkg::OP_PROMPT: begin
				ram_we      = 1'b1;
				ram_wdata   = {attr, tcce_pkg::prompt_char(prompt_q)};
				col_d       = adv_col;
				row_d       = adv_row;
				need_scroll = adv_scroll;
			end
			tcce_pkg::OP_SWEEP: begin
				// fetch the cell one row below for a scroll copy
				if (cmd.sweep_copy && (sweep_q < COPY_END)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(sweep_q + CNT_W'(COLUMNS));
				end
			end
			default: begin
			end
		endcase
		// delayed sweep write owns the write port
		if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = copy_s1 ? ram_rdata : blank_cell;
		end
	end

	// cursor, prompt and flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			prompt_q   <= '0;
			scroll_q   <= 1'b0;
			read_hit_q <= 1'b0;
		end else begin
			col_q      <= col_d;
			row_q      <= row_d;
			read_hit_q <= read_hit_d;
			if (cmd.op == tcce_pkg::OP_EXEC) begin
				prompt_q <= '0;
				scroll_q <= need_scroll;
			end else if (cmd.op == tcce_pkg::OP_PROMPT) begin
				prompt_q <= prompt_q + PW'(1);
				if (need_scroll) begin
					scroll_q <= 1'b1;
				end
			end
		end
	end

	// sweep address counter and write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= 1'b0;
			if (cmd.op == tcce_pkg::OP_EXEC || cmd.op == tcce_pkg::OP_PROMPT) begin
				sweep_q <= '0;
			end else if (cmd.op == tcce_pkg::OP_SWEEP && sweep_q != CNT_END) begin
				wr_v_s1 <= 1'b1;
				sweep_q <= sweep_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= AW'(sweep_q);
		copy_s1    <= cmd.sweep_copy && (sweep_q < COPY_END);
	end

	tcce_ram #(
		.WIDTH(CW),
		.DEPTH(CELLS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp.cursor_index <= tcce_pkg::CIDX_W'(cur_idx);
			rsp.cursor_col   <= tcce_pkg::CCOL_W'(col_q);
			rsp.cursor_row   <= tcce_pkg::CROW_W'(row_q);
			rsp.cell_data    <= read_hit_q ? ram_rdata : '0;
			rsp.scrolled     <= scroll_q;
		end
	end

	// status back to the controller
	assign status.need_scroll  = need_scroll;
	assign status.start_prompt = start_prompt;
	assign status.start_clear  = start_clear;
	assign status.prompt_last  = (prompt_q == PW'(tcce_pkg::PROMPT_LEN - 1));
	assign status.sweep_done   = (sweep_q == CNT_END) && !wr_v_s1;

endmodule

`default_nettype wire

/* design/tcce_ctrl.sv */
`default_nettype none

module tcce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire tcce_pkg::dp_status_t status,
	output tcce_pkg::dp_cmd_t         cmd
);

	tcce_pkg::ctrl_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  resume_prompt_q, resume_d;

	assign req_stall = (state_q != tcce_pkg::ST_IDLE);
	assign rsp_valid = out_valid_q;

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= tcce_pkg::ST_INIT;
			out_valid_q     <= 1'b0;
			resume_prompt_q <= 1'b0;
		end else begin
			state_q         <= state_d;
			out_valid_q     <= cmd.load_out || (out_valid_q && rsp_stall);
			resume_prompt_q <= resume_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d               = state_q;
		resume_d              = resume_prompt_q;
		cmd.op                = tcce_pkg::OP_NONE;
		cmd.sweep_copy        = 1'b0;
		cmd.sweep_reset_blank = 1'b0;
		cmd.load_out          = 1'b0;
		case (state_q)
			tcce_pkg::ST_INIT: begin
				cmd.op                = tcce_pkg::OP_SWEEP;
				cmd.sweep_reset_blank = 1'b1;
				if (status.sweep_done) begin
					state_d = tcce_pkg::ST_IDLE;
				end
			end
			tcce_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.op   = tcce_pkg::OP_EXEC;
					resume_d = status.start_prompt;
					if (status.start_clear) begin
						state_d = tcce_pkg::ST_CLEAR;
					end else if (status.need_scroll) begin
						state_d = tcce_pkg::ST_SCROLL;
					end else if (status.start_prompt) begin
						state_d = tcce_pkg::ST_PROMPT;
					end else begin
						state_d = tcce_pkg::ST_FINISH;
					end
				end
			end
			tcce_pkg::ST_PROMPT: begin
				cmd.op   = tcce_pkg::OP_PROMPT;
				resume_d = !status.prompt_last;
				if (status.need_scroll) begin
					state_d = tcce_pkg::ST_SCROLL;
				end else if (status.prompt_last) begin
					state_d = tcce_pkg::ST_FINISH;
				end
			end
			tcce_pkg::ST_SCROLL: begin
				cmd.op         = tcce_pkg::OP_SWEEP;
				cmd.sweep_copy = 1'b1;
				if (status.sweep_done) begin
					state_d = resume_prompt_q ? tcce_pkg::ST_PROMPT : tcce_pkg::ST_FINISH;
				end
			end
			tcce_pkg::ST_CLEAR: begin
				cmd.op = tcce_pkg::OP_SWEEP;
				if (status.sweep_done) begin
					state_d = tcce_pkg::ST_FINISH;
				end
			end
			tcce_pkg::ST_FINISH: begin
				if (!out_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = tcce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcce_pkg::ST_IDLE;
			end
		endcase
	end

	// a new result never overwrites one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

	// the power-on clearing pass runs to its end
	a_init_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == tcce_pkg::ST_INIT) |-> $past(status.sweep_done))
		else $error("left clearing pass early");

	// prompt resume is only pending around a line feed
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		resume_prompt_q |-> (state_q == tcce_pkg::ST_SCROLL || state_q == tcce_pkg::ST_PROMPT))
		else $error("stale prompt resume");

endmodule

`default_nettype wire

/* design/text_console_cursor_engine_unit.sv */
// Text console with an 80x25 cell store and a cursor.
// Request channel (req_valid / req_stall / req) carries one command per item:
// put character, arrow move, clear screen or read cell. Response channel
// (rsp_valid / rsp_stall / rsp) returns one item per request with the cursor
// after the step, the cell read and a scroll flag, in request order.
// Arrow moves, reads, CR, tab and plain characters pass through an execute
// step and then a step that loads the result register. A line feed adds one
// prompt step per prompt character. A scroll or clear walks the whole cell
// store through the single write port, one cell a cycle.
// One item is in work at a time; a new request is taken while the previous
// result still waits in the output register, and the block holds its result
// (and stops taking requests) when a finished item meets a stalled response.
// After reset the cell store is swept to blanks with attribute 0x0F;
// req_stall stays high meanwhile, while attribute writes on the APB port
// are taken at any time.
`default_nettype none

module text_console_cursor_engine_unit #(
	parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire tcce_pkg::in_item_t               req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output tcce_pkg::out_item_t                   rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tcce_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [31:0]                      pwdata,
	output logic      [31:0]                      prdata,
	output logic                                  pready
);

	logic                 [7:0] attr_q;
	tcce_pkg::dp_cmd_t          cmd;
	tcce_pkg::dp_status_t       status;

	// attribute register on the apb port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == tcce_pkg::REG_ATTR) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcce_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == tcce_pkg::REG_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tcce_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.attr  (attr_q),
		.req   (req),
		.cmd   (cmd),
		.status(status),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire
